### src/pcfe_pkg.sv
// Package for the phase current front end: shared constants and the
// control structs that pass between the top level, the lanes and the merge.
// No dependencies.
package pcfe_pkg;

    localparam int CAL_SHIFT      = 7;
    localparam int CAL_COUNT_BITS = 7;
    localparam int CAL_SAMPLES    = 128;
    localparam int SCALE_BITS     = 24;
    localparam int CUR_BITS       = 32;
    localparam int FRAC_SHIFT     = 15;

    typedef struct packed {
        logic step;
        logic last;
    } cal_ctl_t;

    typedef struct packed {
        logic valid;
        logic done;
    } tag_t;

endpackage

### src/phase_current_front_end_unit.sv
// Two-shunt phase current front end with ADC offset calibration. One sample
// pair enters per clock when not stalled, and one beat of three Q16.16 phase
// currents leaves after the lane pipeline (difference, scale multiply, round
// and saturate) and the merge register that forms U. Both channel lanes run
// side by side. Calibration beats sum 128 sample pairs and load the offsets
// on the last one, which that beat already uses. The user must write the
// scale register through the cfg channel while the block is idle; the block
// does not enforce it. Depends on pcfe_pkg, pcfe_lane and pcfe_merge.
module phase_current_front_end_unit #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [pcfe_pkg::SCALE_BITS-1:0]             cfg_data,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // s_tdata, low to high: sample_a, sample_b, zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,
    // s_tuser: mode
    input  logic                                        s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // m_tdata, low to high: current_u, current_v, current_w
    output logic [3*pcfe_pkg::CUR_BITS-1:0]             m_tdata,
    // m_tuser: cal_done
    output logic                                        m_tuser
);

    localparam int STAGES = 3;
    localparam logic [pcfe_pkg::CAL_COUNT_BITS-1:0] CAL_LAST =
        pcfe_pkg::CAL_COUNT_BITS'(pcfe_pkg::CAL_SAMPLES - 1);

    logic                                   en;
    logic                                   accept;
    logic [pcfe_pkg::SCALE_BITS-1:0]        scale_reg;
    logic [pcfe_pkg::CAL_COUNT_BITS-1:0]    cal_count_reg;
    pcfe_pkg::cal_ctl_t                     cal;
    pcfe_pkg::tag_t                         tag_reg [STAGES];
    logic signed [pcfe_pkg::CUR_BITS-1:0]   cur_v;
    logic signed [pcfe_pkg::CUR_BITS-1:0]   cur_w;

    assign cfg_ready = 1'b1;
    assign s_tready  = en;
    assign accept    = s_tvalid && en;
    assign cal.step  = accept && s_tuser;
    assign cal.last  = (cal_count_reg == CAL_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= '0;
        end
        else if (cfg_valid)
        begin
            scale_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_count_reg <= '0;
        end
        else if (cal.step)
        begin
            cal_count_reg <= cal.last ? '0 : cal_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0].valid <= s_tvalid;
            tag_reg[0].done  <= cal.step && cal.last;
            for (int i = 1; i < STAGES; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    pcfe_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cal     (cal),
        .sample  (s_tdata[SAMPLE_BITS-1:0]),
        .scale   (scale_reg),
        .current (cur_w)
    );

    pcfe_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cal     (cal),
        .sample  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .scale   (scale_reg),
        .current (cur_v)
    );

    pcfe_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag_reg[STAGES-1]),
        .current_v (cur_v),
        .current_w (cur_w),
        .en        (en),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### src/pcfe_lane.sv
// One channel lane: calibration sum and offset, offset-removed difference,
// scale multiply, rounding to Q16.16 and 32-bit saturation.
// Depends on pcfe_pkg.
module pcfe_lane #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  pcfe_pkg::cal_ctl_t                      cal,
    input  logic [SAMPLE_BITS-1:0]                  sample,
    input  logic [pcfe_pkg::SCALE_BITS-1:0]         scale,
    output logic signed [pcfe_pkg::CUR_BITS-1:0]    current
);

    localparam int SUM_BITS  = SAMPLE_BITS + pcfe_pkg::CAL_SHIFT;
    localparam int DIFF_BITS = SUM_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + pcfe_pkg::SCALE_BITS + 1;
    localparam int SH_BITS   = PROD_BITS - pcfe_pkg::FRAC_SHIFT;
    localparam int WIDE      = (SH_BITS > pcfe_pkg::CUR_BITS) ? SH_BITS
                                                              : pcfe_pkg::CUR_BITS + 1;
    localparam logic signed [PROD_BITS-1:0] ROUND =
        PROD_BITS'(2 ** (pcfe_pkg::FRAC_SHIFT - 1));
    localparam logic signed [WIDE-1:0] SAT_HI =
        {{(WIDE - pcfe_pkg::CUR_BITS + 1){1'b0}}, {(pcfe_pkg::CUR_BITS - 1){1'b1}}};
    localparam logic signed [WIDE-1:0] SAT_LO =
        {{(WIDE - pcfe_pkg::CUR_BITS + 1){1'b1}}, {(pcfe_pkg::CUR_BITS - 1){1'b0}}};

    logic [SUM_BITS-1:0]                  sum_reg;
    logic [SUM_BITS-1:0]                  sum_next;
    logic [SUM_BITS-1:0]                  offset_reg;
    logic [SUM_BITS-1:0]                  offset_use;
    logic signed [DIFF_BITS-1:0]          diff_next;
    logic signed [DIFF_BITS-1:0]          diff_reg;
    logic signed [pcfe_pkg::SCALE_BITS:0] scale_s;
    logic signed [PROD_BITS-1:0]          prod_next;
    logic signed [PROD_BITS-1:0]          prod_reg;
    logic signed [PROD_BITS-1:0]          rnd;
    logic signed [SH_BITS-1:0]            sh;
    logic signed [WIDE-1:0]               wide;
    logic signed [pcfe_pkg::CUR_BITS-1:0] cur_next;
    logic signed [pcfe_pkg::CUR_BITS-1:0] cur_reg;

    assign sum_next   = sum_reg + SUM_BITS'(sample);
    assign offset_use = (cal.step && cal.last) ? sum_next : offset_reg;
    assign diff_next  = $signed({1'b0, offset_use})
                      - $signed({1'b0, sample, {pcfe_pkg::CAL_SHIFT{1'b0}}});

    assign scale_s    = $signed({1'b0, scale});
    assign prod_next  = PROD_BITS'(diff_reg) * PROD_BITS'(scale_s);

    assign rnd  = prod_reg + ROUND;
    assign sh   = rnd[PROD_BITS-1:pcfe_pkg::FRAC_SHIFT];
    assign wide = WIDE'(sh);

    always_comb
    begin
        priority if (wide > SAT_HI)
        begin
            cur_next = pcfe_pkg::CUR_BITS'(SAT_HI);
        end
        else if (wide < SAT_LO)
        begin
            cur_next = pcfe_pkg::CUR_BITS'(SAT_LO);
        end
        else
        begin
            cur_next = pcfe_pkg::CUR_BITS'(wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end
        else if (cal.step)
        begin
            if (cal.last)
            begin
                offset_reg <= sum_next;
                sum_reg    <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            prod_reg <= prod_next;
            cur_reg  <= cur_next;
        end
    end

    assign current = cur_reg;

endmodule

### src/pcfe_merge.sv
// Merge stage: joins the two lane currents, forms U = -(V + W) with
// saturation and holds the output beat. Depends on pcfe_pkg.
module pcfe_merge (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pcfe_pkg::tag_t                          tag,
    input  logic signed [pcfe_pkg::CUR_BITS-1:0]    current_v,
    input  logic signed [pcfe_pkg::CUR_BITS-1:0]    current_w,
    output logic                                    en,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [3*pcfe_pkg::CUR_BITS-1:0]         m_tdata,
    output logic                                    m_tuser
);

    localparam int CB = pcfe_pkg::CUR_BITS;
    localparam logic signed [CB+1:0] SAT_HI = {3'b000, {(CB - 1){1'b1}}};
    localparam logic signed [CB+1:0] SAT_LO = {3'b111, {(CB - 1){1'b0}}};

    logic                   valid_reg;
    logic                   done_reg;
    logic signed [CB-1:0]   u_reg;
    logic signed [CB-1:0]   v_reg;
    logic signed [CB-1:0]   w_reg;
    logic signed [CB:0]     sum_vw;
    logic signed [CB+1:0]   neg_vw;
    logic signed [CB-1:0]   u_next;

    assign en     = !valid_reg || m_tready;
    assign sum_vw = (CB + 1)'(current_v) + (CB + 1)'(current_w);
    assign neg_vw = -((CB + 2)'(sum_vw));

    always_comb
    begin
        priority if (neg_vw > SAT_HI)
        begin
            u_next = CB'(SAT_HI);
        end
        else if (neg_vw < SAT_LO)
        begin
            u_next = CB'(SAT_LO);
        end
        else
        begin
            u_next = CB'(neg_vw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            done_reg <= tag.done;
            u_reg    <= u_next;
            v_reg    <= current_v;
            w_reg    <= current_w;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {w_reg, v_reg, u_reg};
    assign m_tuser  = done_reg;

endmodule
